>>> design/pip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg
// Shared constants, request codes and control types for the polygon tester.
// ----------------------------------------------------------------------------
package pip_pkg;

    localparam int MAX_VERTICES_DEF = 32;
    localparam int COORD_WIDTH_DEF  = 16;

    typedef logic [1:0] t_cmd;

    localparam t_cmd CMD_CLEAR  = 2'd0;
    localparam t_cmd CMD_APPEND = 2'd1;
    localparam t_cmd CMD_QUERY  = 2'd2;

    typedef struct packed {
        logic clr;
        logic app;
        logic qstart;
        logic rd_en;
        logic rd_prev;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic busy;
        logic empty;
    } t_dp_stat;

endpackage

>>> design/pip_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_dp
// Vertex memory, per-edge crossing pipeline and result registers.
// ----------------------------------------------------------------------------
module pip_dp import pip_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_dp_cmd                           i_cmd,
    input  logic [$clog2(MAX_VERTICES)-1:0]   i_rd_addr,
    input  logic [COORD_WIDTH-1:0]            i_point_x,
    input  logic [COORD_WIDTH-1:0]            i_point_y,
    output t_dp_stat                          o_stat,
    output logic [$clog2(MAX_VERTICES+1)-1:0] o_count,
    output logic                              o_inside_res,
    output logic                              o_on_boundary,
    output logic                              o_vertices_dropped
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;

    logic [COORD_WIDTH-1:0] mem_x [MAX_VERTICES];
    logic [COORD_WIDTH-1:0] mem_y [MAX_VERTICES];

    logic [NW-1:0] r_count;
    logic          r_ovf;
    logic          full;

    logic signed [COORD_WIDTH-1:0] r_px, r_py;
    logic                          r_rd_v, r_rd_prev;
    logic signed [COORD_WIDTH-1:0] r_rd_x, r_rd_y;
    logic signed [COORD_WIDTH-1:0] r_prev_x, r_prev_y;

    logic signed [DW-1:0] n_a, n_dy, n_b, n_c;
    logic                 n_strad, n_hit;
    logic signed [DW-1:0] r_a, r_dy, r_b, r_c;
    logic                 r_b_v, r_b_strad, r_b_hit;

    logic signed [PW-1:0] n_p1, n_p2;
    logic signed [PW-1:0] r_p1, r_p2;
    logic                 r_c_v, r_c_strad, r_c_hit, r_c_dyneg;

    logic signed [SW-1:0] n_sum;
    logic                 r_inside, r_bound;
    logic                 r_o_inside, r_o_bound, r_o_drop;

    assign full = (r_count == NW'(MAX_VERTICES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.clr) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.app) begin
            if (full) begin
                r_ovf <= 1'b1;
            end else begin
                r_count <= r_count + NW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.app && !full) begin
            mem_x[r_count[AW-1:0]] <= i_point_x;
            mem_y[r_count[AW-1:0]] <= i_point_y;
        end
        if (i_cmd.rd_en) begin
            r_rd_x <= mem_x[i_rd_addr];
            r_rd_y <= mem_y[i_rd_addr];
        end
    end

    // edge runs from the vertex just read back to the one read before it
    assign n_a     = {r_rd_x[COORD_WIDTH-1], r_rd_x} - {r_px[COORD_WIDTH-1], r_px};
    assign n_dy    = {r_prev_y[COORD_WIDTH-1], r_prev_y} - {r_rd_y[COORD_WIDTH-1], r_rd_y};
    assign n_b     = {r_py[COORD_WIDTH-1], r_py} - {r_rd_y[COORD_WIDTH-1], r_rd_y};
    assign n_c     = {r_prev_x[COORD_WIDTH-1], r_prev_x} - {r_rd_x[COORD_WIDTH-1], r_rd_x};
    assign n_strad = (r_rd_y < r_py) != (r_prev_y < r_py);
    assign n_hit   = ((r_rd_x == r_px) && (r_rd_y == r_py))
                  || ((r_prev_x == r_px) && (r_prev_y == r_py));

    assign n_p1  = PW'(r_a) * PW'(r_dy);
    assign n_p2  = PW'(r_b) * PW'(r_c);
    assign n_sum = SW'(r_p1) + SW'(r_p2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
            r_b_v  <= 1'b0;
            r_c_v  <= 1'b0;
        end else begin
            r_rd_v <= i_cmd.rd_en;
            r_b_v  <= r_rd_v && !r_rd_prev;
            r_c_v  <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_prev <= i_cmd.rd_prev;
        if (i_cmd.qstart) begin
            r_px <= i_point_x;
            r_py <= i_point_y;
        end
        if (r_rd_v) begin
            r_prev_x <= r_rd_x;
            r_prev_y <= r_rd_y;
        end
        r_a       <= n_a;
        r_dy      <= n_dy;
        r_b       <= n_b;
        r_c       <= n_c;
        r_b_strad <= n_strad;
        r_b_hit   <= n_hit;
        r_p1      <= n_p1;
        r_p2      <= n_p2;
        r_c_strad <= r_b_strad;
        r_c_hit   <= r_b_hit;
        r_c_dyneg <= r_dy[DW-1];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.qstart) begin
            r_inside <= 1'b0;
            r_bound  <= 1'b0;
        end else if (r_c_v) begin
            if (r_c_hit || (r_c_strad && (n_sum == '0))) begin
                r_bound <= 1'b1;
            end else if (r_c_strad && (n_sum[SW-1] == r_c_dyneg)) begin
                r_inside <= !r_inside;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_inside <= r_inside || r_bound;
            r_o_bound  <= r_bound;
            r_o_drop   <= r_ovf;
        end
    end

    assign o_stat.busy        = r_rd_v || r_b_v || r_c_v;
    assign o_stat.empty       = (r_count == '0);
    assign o_count            = r_count;
    assign o_inside_res       = r_o_inside;
    assign o_on_boundary      = r_o_bound;
    assign o_vertices_dropped = r_o_drop;

endmodule

>>> design/pip_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_ctrl
// Request decode, edge scan sequencing and result handshake.
// ----------------------------------------------------------------------------
module pip_ctrl import pip_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  t_cmd                              i_cmd,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    input  t_dp_stat                          i_stat,
    input  logic [$clog2(MAX_VERTICES+1)-1:0] i_count,
    output t_dp_cmd                           o_cmd,
    output logic [$clog2(MAX_VERTICES)-1:0]   o_rd_addr
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREV  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_idx, n_idx;
    logic          r_out_valid, n_out_valid;
    logic          accept;
    logic [AW-1:0] last;

    assign accept = i_in_valid && (r_state == S_IDLE);
    assign last   = AW'(i_count - NW'(1));

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_rd_addr   = r_idx;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        CMD_CLEAR:  o_cmd.clr = 1'b1;
                        CMD_APPEND: o_cmd.app = 1'b1;
                        CMD_QUERY: begin
                            o_cmd.qstart = 1'b1;
                            n_state = i_stat.empty ? S_DONE : S_PREV;
                        end
                        default: ;
                    endcase
                end
            end
            S_PREV: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_prev = 1'b1;
                o_rd_addr     = last;
                n_idx         = '0;
                n_state       = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (r_idx == last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            S_DRAIN: begin
                if (!i_stat.busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> design/point_in_polygon_test_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_test_unit
// Crossing-number point-in-polygon tester over a stored vertex list.
// ----------------------------------------------------------------------------
// Clear and append requests return nothing; an append past MAX_VERTICES is
// dropped and reported with the next query results. A query walks the
// stored edges one per cycle through a single read port of the vertex
// memory and a subtract/multiply/add pipeline, and its result waits while
// the previous result is still held by the receiver. Points on a vertex or
// on a non-horizontal edge report inside and on boundary.
module point_in_polygon_test_unit import pip_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [1:0]             i_cmd,
    input  logic [COORD_WIDTH-1:0] i_point_x,
    input  logic [COORD_WIDTH-1:0] i_point_y,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_inside_res,
    output logic                   o_on_boundary,
    output logic                   o_vertices_dropped
);

    t_dp_cmd                           dp_cmd;
    t_dp_stat                          dp_stat;
    logic [$clog2(MAX_VERTICES+1)-1:0] count;
    logic [$clog2(MAX_VERTICES)-1:0]   rd_addr;

    pip_ctrl #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (dp_stat),
        .i_count     (count),
        .o_cmd       (dp_cmd),
        .o_rd_addr   (rd_addr)
    );

    pip_dp #(
        .MAX_VERTICES(MAX_VERTICES),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (dp_cmd),
        .i_rd_addr          (rd_addr),
        .i_point_x          (i_point_x),
        .i_point_y          (i_point_y),
        .o_stat             (dp_stat),
        .o_count            (count),
        .o_inside_res       (o_inside_res),
        .o_on_boundary      (o_on_boundary),
        .o_vertices_dropped (o_vertices_dropped)
    );

endmodule

>>> design/pip_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_chk
// Port-level checks for the polygon tester, bound to the top level.
// ----------------------------------------------------------------------------
module pip_chk import pip_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [1:0] i_cmd,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_inside_res,
    input logic       o_on_boundary,
    input logic       o_vertices_dropped
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid
            && $stable(o_inside_res) && $stable(o_on_boundary)
            && $stable(o_vertices_dropped))
        else $error("stalled result changed");

    a_bound_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_on_boundary |-> o_inside_res)
        else $error("boundary point not reported inside");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_cmd != CMD_QUERY) && !o_out_valid
            |=> !o_out_valid)
        else $error("result from a non-query request");

endmodule

bind point_in_polygon_test_unit pip_chk u_pip_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_stall         (o_in_stall),
    .i_cmd              (i_cmd),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_inside_res       (o_inside_res),
    .o_on_boundary      (o_on_boundary),
    .o_vertices_dropped (o_vertices_dropped)
);

>>> dv/pip_verdict_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_verdict_checker
// Watches both channels of the polygon tester, keeps its own copy of the
// vertex list, works out the verdict of every query by an exact crossing
// count and compares each returned result with the oldest verdict pending.
// ----------------------------------------------------------------------------
module pip_verdict_checker import pip_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  t_cmd                   i_cmd,
    input  logic [COORD_WIDTH-1:0] i_point_x,
    input  logic [COORD_WIDTH-1:0] i_point_y,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic                   i_inside_res,
    input  logic                   i_on_boundary,
    input  logic                   i_vertices_dropped,
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct packed {
        logic in_poly;
        logic boundary;
        logic dropped;
    } t_verdict;

    longint   corner_x [MAX_VERTICES];
    longint   corner_y [MAX_VERTICES];
    int       corner_count = 0;
    bit       dropped_flag = 1'b0;
    int       fail_tally   = 0;
    t_verdict pending_verdicts[$];

    function automatic t_verdict judge_point(input longint px, input longint py);
        t_verdict v;
        bit       odd_crossings;
        bit       on_edge;
        int       i;
        int       j;
        longint   sx;
        longint   sy;
        longint   ex;
        longint   ey;
        longint   dy;
        longint   num;
        int       s;
        odd_crossings = 1'b0;
        on_edge       = 1'b0;
        if (corner_count > 0) begin
            j = corner_count - 1;
            for (i = 0; i < corner_count && !on_edge; i++) begin
                sx = corner_x[i];
                sy = corner_y[i];
                ex = corner_x[j];
                ey = corner_y[j];
                if ((sx == px && sy == py) || (ex == px && ey == py)) begin
                    on_edge = 1'b1;
                end else if ((sy < py && ey >= py) || (sy >= py && ey < py)) begin
                    dy  = ey - sy;
                    num = (sx - px) * dy + (py - sy) * (ex - sx);
                    s   = (num > 0) ? 1 : ((num < 0) ? -1 : 0);
                    if (dy < 0) begin
                        s = -s;
                    end
                    if (s == 0) begin
                        on_edge = 1'b1;
                    end else if (s > 0) begin
                        odd_crossings = !odd_crossings;
                    end
                end
                j = i;
            end
        end
        v.in_poly  = odd_crossings | on_edge;
        v.boundary = on_edge;
        v.dropped  = dropped_flag;
        return v;
    endfunction

    always @(posedge i_clk) begin : watch
        t_verdict want;
        t_verdict fresh;
        if (!i_rst_n) begin
            corner_count = 0;
            dropped_flag = 1'b0;
            pending_verdicts.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_verdicts.size() == 0) begin
                    $error("result with no query pending: inside_res %0b on_boundary %0b",
                           i_inside_res, i_on_boundary);
                    fail_tally++;
                end else begin
                    want = pending_verdicts.pop_front();
                    if (i_inside_res !== want.in_poly) begin
                        $error("inside_res: expected %0b, actual %0b",
                               want.in_poly, i_inside_res);
                        fail_tally++;
                    end
                    if (i_on_boundary !== want.boundary) begin
                        $error("on_boundary: expected %0b, actual %0b",
                               want.boundary, i_on_boundary);
                        fail_tally++;
                    end
                    if (i_vertices_dropped !== want.dropped) begin
                        $error("vertices_dropped: expected %0b, actual %0b",
                               want.dropped, i_vertices_dropped);
                        fail_tally++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_cmd)
                    CMD_CLEAR: begin
                        corner_count = 0;
                        dropped_flag = 1'b0;
                    end
                    CMD_APPEND: begin
                        if (corner_count < MAX_VERTICES) begin
                            corner_x[corner_count] = longint'($signed(i_point_x));
                            corner_y[corner_count] = longint'($signed(i_point_y));
                            corner_count++;
                        end else begin
                            dropped_flag = 1'b1;
                        end
                    end
                    CMD_QUERY: begin
                        fresh = judge_point(longint'($signed(i_point_x)),
                                            longint'($signed(i_point_y)));
                        pending_verdicts.insert(pending_verdicts.size(), fresh);
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending    <= pending_verdicts.size();
        o_fail_count <= fail_tally;
    end

endmodule

>>> dv/point_in_polygon_test_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_test_unit_tb
// Builds polygons of many sizes and scales, including overfull ones, and
// queries points on vertices, on edges, near edges and anywhere, with random
// gaps on the request side and random stalls on the result side. A checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module point_in_polygon_test_unit_tb;
    import pip_pkg::*;

    localparam int   VERTS          = MAX_VERTICES_DEF;
    localparam int   CW             = COORD_WIDTH_DEF;
    localparam int   MINC           = -(1 << (CW - 1));
    localparam int   MAXC           = (1 << (CW - 1)) - 1;
    localparam t_cmd CMD_UNUSED     = 2'd3;
    localparam int   REQUEST_TARGET = 750;
    localparam int   CYCLE_LIMIT    = 600000;

    logic          clk          = 1'b0;
    logic          rst_n        = 1'b0;
    logic          req_valid    = 1'b0;
    logic          req_stall;
    t_cmd          req_cmd      = CMD_CLEAR;
    logic [CW-1:0] req_x        = '0;
    logic [CW-1:0] req_y        = '0;
    logic          res_valid;
    logic          res_stall    = 1'b0;
    logic          res_inside;
    logic          res_boundary;
    logic          res_dropped;

    int fail_count;
    int pending;
    int cycle_count   = 0;
    int request_count = 0;
    bit burst         = 1'b0;
    int shape_x[$];
    int shape_y[$];

    always #5 clk = ~clk;

    point_in_polygon_test_unit #(
        .MAX_VERTICES(VERTS),
        .COORD_WIDTH (CW)
    ) u_top (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (req_valid),
        .o_in_stall        (req_stall),
        .i_cmd             (req_cmd),
        .i_point_x         (req_x),
        .i_point_y         (req_y),
        .o_out_valid       (res_valid),
        .i_out_stall       (res_stall),
        .o_inside_res      (res_inside),
        .o_on_boundary     (res_boundary),
        .o_vertices_dropped(res_dropped)
    );

    pip_verdict_checker #(
        .MAX_VERTICES(VERTS),
        .COORD_WIDTH (CW)
    ) u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (req_valid),
        .i_in_stall        (req_stall),
        .i_cmd             (req_cmd),
        .i_point_x         (req_x),
        .i_point_y         (req_y),
        .i_out_valid       (res_valid),
        .i_out_stall       (res_stall),
        .i_inside_res      (res_inside),
        .i_on_boundary     (res_boundary),
        .i_vertices_dropped(res_dropped),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("point_in_polygon_test_unit: mismatch");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_coord(input int span);
        if (span == 0) begin
            return int'($urandom_range(0, (1 << CW) - 1)) + MINC;
        end
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic send_request(input t_cmd c, input int x, input int y);
        int gap;
        gap = burst ? 0 : pick_gap();
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_cmd   <= c;
        req_x     <= x[CW-1:0];
        req_y     <= y[CW-1:0];
        @(posedge clk);
        while (req_stall) @(posedge clk);
        @(negedge clk);
        if (c != CMD_UNUSED) begin
            request_count++;
        end
        if (c == CMD_CLEAR) begin
            shape_x.delete();
            shape_y.delete();
        end else if (c == CMD_APPEND && shape_x.size() < VERTS) begin
            shape_x.insert(shape_x.size(), x);
            shape_y.insert(shape_y.size(), y);
        end
    endtask

    task automatic query_point(input int span);
        int r;
        int k;
        int kn;
        int x;
        int y;
        r = $urandom_range(0, 99);
        if (shape_x.size() == 0 || r < 45) begin
            x = pick_coord(span);
            y = pick_coord(span);
        end else begin
            k = $urandom_range(0, shape_x.size() - 1);
            if (r < 65) begin
                x = shape_x[k];
                y = shape_y[k];
            end else begin
                kn = (k + 1) % shape_x.size();
                x  = (shape_x[k] + shape_x[kn]) >>> 1;
                y  = (shape_y[k] + shape_y[kn]) >>> 1;
                if (r >= 88) begin
                    x = x + int'($urandom_range(0, 2)) - 1;
                    y = y + int'($urandom_range(0, 2)) - 1;
                end
            end
        end
        send_request(CMD_QUERY, x, y);
    endtask

    task automatic run_shape();
        int r;
        int n;
        int span;
        int q;
        int k;
        burst = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) != 0) begin
            send_request(CMD_CLEAR, pick_coord(0), pick_coord(0));
        end
        r = $urandom_range(0, 99);
        if (r < 10) begin
            n = $urandom_range(1, 2);
        end else if (r < 80) begin
            n = $urandom_range(3, 8);
        end else if (r < 92) begin
            n = $urandom_range(9, VERTS - 1);
        end else begin
            n = $urandom_range(VERTS, VERTS + 4);
        end
        r = $urandom_range(0, 99);
        span = (r < 50) ? 20 : ((r < 85) ? 2000 : 0);
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 19) == 0) begin
                send_request(CMD_UNUSED, pick_coord(0), pick_coord(0));
            end
            if ($urandom_range(0, 29) == 0) begin
                query_point(span);
            end
            send_request(CMD_APPEND, pick_coord(span), pick_coord(span));
        end
        q = $urandom_range(2, 8);
        for (k = 0; k < q; k++) begin
            query_point(span);
        end
    endtask

    initial begin : result_side
        int r;
        int run;
        forever begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                res_stall <= 1'b0;
                run = $urandom_range(40, 150);
            end else if (r < 60) begin
                res_stall <= 1'b0;
                run = $urandom_range(1, 6);
            end else if (r < 93) begin
                res_stall <= 1'b1;
                run = $urandom_range(1, 3);
            end else begin
                res_stall <= 1'b1;
                run = $urandom_range(10, 40);
            end
            repeat (run) @(negedge clk);
        end
    end

    initial begin : request_side
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        send_request(CMD_QUERY, 0, 0);
        send_request(CMD_QUERY, MINC, MAXC);
        send_request(CMD_UNUSED, MAXC, MINC);
        send_request(CMD_APPEND, MINC, MINC);
        send_request(CMD_APPEND, MAXC, MINC);
        send_request(CMD_APPEND, MAXC, MAXC);
        send_request(CMD_APPEND, MINC, MAXC);
        send_request(CMD_QUERY, 0, 0);
        send_request(CMD_QUERY, MINC, 0);
        send_request(CMD_QUERY, 0, MINC);
        send_request(CMD_QUERY, MAXC, MAXC);
        send_request(CMD_CLEAR, MAXC, MAXC);
        send_request(CMD_APPEND, 0, 0);
        send_request(CMD_QUERY, 0, 0);
        send_request(CMD_QUERY, 1, 1);
        send_request(CMD_APPEND, 100, 50);
        send_request(CMD_QUERY, 50, 25);
        send_request(CMD_APPEND, 0, 100);
        send_request(CMD_QUERY, 10, 50);
        send_request(CMD_QUERY, -1, 50);
        send_request(CMD_QUERY, 200, 50);
        send_request(CMD_UNUSED, -1, -1);
        send_request(CMD_CLEAR, 0, 0);
        send_request(CMD_QUERY, 0, 0);

        while (request_count < REQUEST_TARGET) begin
            run_shape();
        end
        req_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (VERTS + 16) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("point_in_polygon_test_unit: match");
        end else begin
            $display("point_in_polygon_test_unit: mismatch");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/pip_pkg.sv
design/pip_dp.sv
design/pip_ctrl.sv
design/point_in_polygon_test_unit.sv
design/pip_chk.sv
dv/pip_verdict_checker.sv
dv/point_in_polygon_test_unit_tb.sv
